// File: hw/rtl/pcsum_pkg.sv
// shared types and constants for the packet checksum acknowledgement checker
// no dependencies
`default_nettype none

package pcsum_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CSUM_W = 16;
	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned KIND_W = 2;

	typedef logic [BYTE_W-1:0]        byte_t;
	typedef logic [CSUM_W-1:0]        csum_t;
	typedef logic signed [SEQ_W-1:0]  seq_t;
	typedef logic [KIND_W-1:0]        kind_t;

	// acknowledgement kinds
	localparam kind_t KIND_SEQ   = 2'd0;
	localparam kind_t KIND_FINAL = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	// special sequence and ack words
	localparam seq_t SEQ_RESET_VALUE = -32'sd2;
	localparam seq_t SEQ_FINAL       = -32'sd1;
	localparam seq_t ACK_ERROR_VALUE = -32'sd5;
	localparam seq_t ACK_FINAL_VALUE = 32'sd0;

	// per-beat control handed to the checksum accumulator
	typedef struct packed {
		logic fire;
		logic present;
		logic last;
	} pcsum_step_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcsum_if.sv
// valid/ready channel interfaces for the packet beats and the acknowledgements
// depends on pcsum_pkg
`default_nettype none

interface pcsum_pkt_if;
	import pcsum_pkg::*;

	logic  valid;
	logic  ready;
	byte_t byte_data;
	logic  byte_present;
	logic  last_byte;
	seq_t  seq_number;
	csum_t received_checksum;

	modport source (
		output valid, byte_data, byte_present, last_byte, seq_number, received_checksum,
		input  ready
	);
	modport sink (
		input  valid, byte_data, byte_present, last_byte, seq_number, received_checksum,
		output ready
	);
endinterface

interface pcsum_ack_if;
	import pcsum_pkg::*;

	logic  valid;
	logic  ready;
	seq_t  ack_value;
	kind_t ack_kind;

	modport source (output valid, ack_value, ack_kind, input ready);
	modport sink (input valid, ack_value, ack_kind, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/packet_checksum_ack_checker.sv
// Packet checksum acknowledgement checker.
//
// pkt (sink): one beat per message byte, valid/ready; byte_present marks a
// beat that carries a byte, last_byte ends the packet and on that beat
// seq_number and received_checksum are sampled.
// ack (source): at most one beat per packet, sent on its last beat unless
// the sequence number repeats the previous one. ack_kind tells an in-sequence
// ack, a final-packet ack (value 0) or a checksum error (value -5).
//
// A last beat is loaded into the input register when accepted, and its ack is
// loaded from there into the ack output register.
// Throughput is one beat per cycle unless a beat that makes an ack waits on
// a stalled ack; the checksum update is a single 16-bit end-around add per beat.
// When ack stalls, beats that make no ack keep flowing; a beat that makes an
// ack waits in the input register until the output register frees up.
// Reset clears the running sum and pending byte, empties both registers and
// sets the previous sequence number to -2.
// depends on pcsum_pkg, pcsum_if, pcsum_accum
`default_nettype none

module packet_checksum_ack_checker (
	input wire logic   clk,
	input wire logic   arst_n,
	pcsum_pkt_if.sink  pkt,
	pcsum_ack_if.source ack
);
	import pcsum_pkg::*;

	// input register
	logic  valid_s1;
	byte_t byte_s1;
	logic  present_s1;
	logic  last_s1;
	seq_t  seq_s1;
	csum_t rx_sum_s1;

	seq_t  prev_seq_q;
	logic  out_valid_q;
	seq_t  ack_value_q;
	kind_t ack_kind_q;

	logic        has_ack;
	logic        adv;
	logic        load_ack;
	pcsum_step_t step;
	csum_t       checksum;
	seq_t        value_d;
	kind_t       kind_d;

	// stage advance: beats without an ack never wait on the output
	always_comb begin
		has_ack  = last_s1 && (seq_s1 != prev_seq_q);
		adv      = !has_ack || !out_valid_q || ack.ready;
		load_ack = valid_s1 && adv && has_ack;
		step.fire    = valid_s1 && adv;
		step.present = present_s1;
		step.last    = last_s1;
	end

	assign pkt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			byte_s1    <= pkt.byte_data;
			present_s1 <= pkt.byte_present;
			last_s1    <= pkt.last_byte;
			seq_s1     <= pkt.seq_number;
			rx_sum_s1  <= pkt.received_checksum;
		end
	end

	pcsum_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_data (byte_s1),
		.checksum  (checksum)
	);

	// ack word selection, error before final
	always_comb begin
		if (checksum != rx_sum_s1) begin
			value_d = ACK_ERROR_VALUE;
			kind_d  = KIND_ERROR;
		end else if (seq_s1 == SEQ_FINAL) begin
			value_d = ACK_FINAL_VALUE;
			kind_d  = KIND_FINAL;
		end else begin
			value_d = seq_s1;
			kind_d  = KIND_SEQ;
		end
	end

	// previous sequence tracks every non-duplicate last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_q <= SEQ_RESET_VALUE;
		end else if (load_ack) begin
			prev_seq_q <= seq_s1;
		end
	end

	// ack output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ack) begin
			out_valid_q <= 1'b1;
		end else if (ack.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ack) begin
			ack_value_q <= value_d;
			ack_kind_q  <= kind_d;
		end
	end

	assign ack.valid     = out_valid_q;
	assign ack.ack_value = ack_value_q;
	assign ack.ack_kind  = ack_kind_q;

endmodule

`default_nettype wire

// File: hw/rtl/pcsum_accum.sv
// ones'-complement checksum accumulator: pairs bytes low first, folds the odd tail
// depends on pcsum_pkg
`default_nettype none

module pcsum_accum (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pcsum_pkg::pcsum_step_t step,
	input  wire pcsum_pkg::byte_t     byte_data,
	output pcsum_pkg::csum_t          checksum
);
	import pcsum_pkg::*;

	csum_t sum_q;
	byte_t held_q;
	logic  pend_q;

	logic  pair;
	logic  pend_n;
	byte_t held_n;
	csum_t sum_pair;
	csum_t sum_n;
	csum_t sum_tail;
	csum_t sum_final;

	// add with end-around carry; a single fold cannot carry again
	function automatic csum_t oc_add(input csum_t a, input csum_t b);
		logic [CSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, s[CSUM_W]};
	endfunction

	// next pairing state
	always_comb begin
		pair     = step.present && pend_q;
		pend_n   = step.present ? !pend_q : pend_q;
		if (step.present && !pend_q) begin
			held_n = byte_data;
		end else if (pair) begin
			held_n = '0;
		end else begin
			held_n = held_q;
		end
		sum_pair = oc_add(sum_q, {byte_data, held_q});
		sum_n    = pair ? sum_pair : sum_q;
		// odd tail: while a byte stays pending, it is added as a low byte with a zero high byte
		sum_tail  = oc_add(sum_q, {{(CSUM_W-BYTE_W){1'b0}}, held_n});
		sum_final = pend_n ? sum_tail : sum_n;
		checksum  = ~sum_final;
	end

	// packet state, cleared on every last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			held_q <= '0;
			pend_q <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				sum_q  <= '0;
				held_q <= '0;
				pend_q <= 1'b0;
			end else begin
				sum_q  <= sum_n;
				held_q <= held_n;
				pend_q <= pend_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: tb/pcsum_ack_scoreboard.sv
// scoreboard for the packet checksum acknowledgement checker: predicts acks from packet beats
// and compares them with what comes out; depends on pcsum_pkg and pcsum_if
`timescale 1ns / 1ps

module pcsum_ack_scoreboard (
	input wire logic clk,
	input wire logic arst_n,
	pcsum_pkt_if     pkt,
	pcsum_ack_if     ack,
	output int       fail_count,
	output int       pending,
	output int       ack_count,
	output int       err_count,
	output int       final_count
);
	import pcsum_pkg::*;

	typedef struct packed {
		seq_t  value;
		kind_t kind;
	} ack_word_t;

	ack_word_t expected_acks[$];
	csum_t     sum_acc;
	byte_t     low_hold;
	logic      odd_hold;
	seq_t      prev_seq;

	// 16-bit add with end-around carry
	function automatic csum_t ones_add(csum_t a, csum_t b);
		logic [CSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CSUM_W-1:0] + csum_t'(s[CSUM_W]);
	endfunction

	task automatic note_fail(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// fold one accepted packet beat into the running checksum, queue an ack on the last beat
	task automatic predict_beat();
		csum_t     total;
		ack_word_t exp;
		if (pkt.byte_present) begin
			if (odd_hold) begin
				sum_acc  = ones_add(sum_acc, {pkt.byte_data, low_hold});
				low_hold = '0;
				odd_hold = 1'b0;
			end else begin
				low_hold = pkt.byte_data;
				odd_hold = 1'b1;
			end
		end
		if (pkt.last_byte) begin
			total    = odd_hold ? ones_add(sum_acc, {8'h00, low_hold}) : sum_acc;
			total    = ~total;
			sum_acc  = '0;
			low_hold = '0;
			odd_hold = 1'b0;
			// a repeated sequence number is dropped without any ack
			if (pkt.seq_number != prev_seq) begin
				prev_seq = pkt.seq_number;
				if (total != pkt.received_checksum)
					exp = '{ACK_ERROR_VALUE, KIND_ERROR};
				else if (pkt.seq_number == SEQ_FINAL)
					exp = '{ACK_FINAL_VALUE, KIND_FINAL};
				else
					exp = '{pkt.seq_number, KIND_SEQ};
				expected_acks.push_back(exp);
			end
		end
	endtask

	// compare one ack beat against the oldest prediction
	task automatic check_ack();
		ack_word_t exp;
		if (expected_acks.size() == 0) begin
			note_fail($sformatf("unexpected ack value %0d kind %0d", ack.ack_value, ack.ack_kind));
		end else begin
			exp = expected_acks.pop_front();
			ack_count++;
			if (exp.kind == KIND_ERROR)
				err_count++;
			if (exp.kind == KIND_FINAL)
				final_count++;
			if (ack.ack_value !== exp.value)
				note_fail($sformatf("ack_value expected %0d, got %0d", exp.value, ack.ack_value));
			if (ack.ack_kind !== exp.kind)
				note_fail($sformatf("ack_kind expected %0d, got %0d", exp.kind, ack.ack_kind));
		end
	endtask

	// acks are checked before the new packet beat, an ack never answers a beat of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_acks.delete();
			sum_acc     = '0;
			low_hold    = '0;
			odd_hold    = 1'b0;
			prev_seq    = SEQ_RESET_VALUE;
			fail_count  = 0;
			ack_count   = 0;
			err_count   = 0;
			final_count = 0;
			pending     = 0;
		end else begin
			if (ack.valid === 1'b1 && ack.ready === 1'b1)
				check_ack();
			if (pkt.valid === 1'b1 && pkt.ready === 1'b1)
				predict_beat();
			pending = expected_acks.size();
		end
	end

endmodule

// File: tb/tb_packet_checksum_ack_checker.sv
// top of the packet checksum acknowledgement checker testbench: clock, reset, packet stimulus
// and ack back-pressure; depends on pcsum_pkg, pcsum_if, the block and pcsum_ack_scoreboard
`timescale 1ns / 1ps

module tb_packet_checksum_ack_checker;
	import pcsum_pkg::*;

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_stall;
	int   beats_sent;
	int   fail_count;
	int   pending;
	int   ack_count;
	int   err_count;
	int   final_count;
	seq_t seq_cursor;
	int   idle_tab [4] = '{0, 79, 0, 12};
	int   stall_tab[4] = '{0, 0, 79, 12};

	pcsum_pkt_if pkt_if ();
	pcsum_ack_if ack_if ();

	packet_checksum_ack_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_if),
		.ack    (ack_if)
	);

	pcsum_ack_scoreboard u_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt         (pkt_if),
		.ack         (ack_if),
		.fail_count  (fail_count),
		.pending     (pending),
		.ack_count   (ack_count),
		.err_count   (err_count),
		.final_count (final_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#400000;
		$display("timeout with %0d acks still outstanding", pending);
		$display("Regression FAIL");
		$finish;
	end

	// ack back-pressure
	initial begin
		ack_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			ack_if.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// checksum the sender puts in the header: deferred carries, folded at the end
	function automatic csum_t message_csum(byte_t msg[$]);
		logic [31:0] acc;
		acc = '0;
		for (int i = 0; i < msg.size(); i++)
			acc += i[0] ? {16'h0, msg[i], 8'h00} : {24'h0, msg[i]};
		while (acc[31:16] != 0)
			acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
		return ~acc[15:0];
	endfunction

	// present one beat, with random sender gaps, and hold it until accepted
	task automatic send_beat(byte_t data, logic present, logic last, seq_t seq, csum_t rx);
		while ($urandom_range(99) < send_idle) begin
			pkt_if.valid <= 1'b0;
			@(posedge clk);
		end
		pkt_if.valid             <= 1'b1;
		pkt_if.byte_data         <= data;
		pkt_if.byte_present      <= present;
		pkt_if.last_byte         <= last;
		pkt_if.seq_number        <= seq;
		pkt_if.received_checksum <= rx;
		@(posedge clk);
		while (pkt_if.ready !== 1'b1)
			@(posedge clk);
		beats_sent++;
	endtask

	// one packet: message bytes with optional empty beats between them, header on the last beat
	task automatic send_packet(byte_t msg[$], seq_t seq, bit corrupt, int noise_pct);
		csum_t rx;
		int    n;
		bit    tail_has_byte;
		rx = message_csum(msg);
		if (corrupt)
			rx ^= csum_t'($urandom_range(65535, 1));
		n = msg.size();
		tail_has_byte = (n > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < n; i++) begin
			while ($urandom_range(99) < noise_pct)
				send_beat(byte_t'($urandom), 1'b0, 1'b0, seq_t'($urandom), csum_t'($urandom));
			if (i == n - 1 && tail_has_byte)
				send_beat(msg[i], 1'b1, 1'b1, seq, rx);
			else
				send_beat(msg[i], 1'b1, 1'b0, seq_t'($urandom), csum_t'($urandom));
		end
		if (!tail_has_byte)
			send_beat(byte_t'($urandom), 1'b0, 1'b1, seq, rx);
		seq_cursor = seq;
	endtask

	// mostly in-order packets, with repeats, final packets, wild sequence numbers and bad sums
	task automatic random_packet();
		byte_t msg[$];
		int    len;
		int    pick;
		seq_t  seq;
		len = ($urandom_range(99) < 85) ? $urandom_range(9) : $urandom_range(40, 10);
		for (int i = 0; i < len; i++)
			msg.push_back(byte_t'($urandom));
		pick = $urandom_range(99);
		if (pick < 70)
			seq = seq_cursor + 1;
		else if (pick < 80)
			seq = seq_cursor;
		else if (pick < 88)
			seq = SEQ_FINAL;
		else
			seq = seq_t'($urandom);
		send_packet(msg, seq, $urandom_range(99) < 15, ($urandom_range(1) == 1) ? 0 : 20);
	endtask

	// stop sending and wait for every outstanding ack
	task automatic settle();
		pkt_if.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	// stimulus
	initial begin
		byte_t msg[$];
		int    target;
		arst_n                   <= 1'b0;
		pkt_if.valid             <= 1'b0;
		pkt_if.byte_data         <= '0;
		pkt_if.byte_present      <= 1'b0;
		pkt_if.last_byte         <= 1'b0;
		pkt_if.seq_number        <= '0;
		pkt_if.received_checksum <= '0;
		send_idle  = 0;
		recv_stall = 0;
		beats_sent = 0;
		seq_cursor = SEQ_RESET_VALUE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message whose sequence matches the reset value: dropped
		msg = {};
		send_packet(msg, SEQ_RESET_VALUE, 1'b0, 0);
		// empty message, good sum
		send_packet(msg, seq_t'(0), 1'b0, 0);
		// zero bytes count as data
		msg = '{8'h00, 8'h00};
		send_packet(msg, seq_t'(1), 1'b0, 0);
		// all-ones bytes, odd length, largest sequence number
		msg = '{8'hFF, 8'hFF, 8'hFF};
		send_packet(msg, seq_t'(32'h7FFF_FFFF), 1'b0, 0);
		// repeated sequence number with a bad sum: still dropped
		msg = '{8'h12};
		send_packet(msg, seq_t'(32'h7FFF_FFFF), 1'b1, 0);
		// bad sum, most negative sequence number
		msg = '{8'hAB};
		send_packet(msg, seq_t'(32'h8000_0000), 1'b1, 0);
		// final packet with empty beats mixed in
		msg = '{8'h01, 8'h02, 8'h03};
		send_packet(msg, SEQ_FINAL, 1'b0, 30);
		msg = '{8'h5A, 8'hA5};
		send_packet(msg, seq_t'(5), 1'b0, 0);
		// bad sum on a final packet: error wins
		msg = {};
		send_packet(msg, SEQ_FINAL, 1'b1, 0);
		msg = '{8'h80, 8'h7F, 8'h01};
		send_packet(msg, seq_t'(6), 1'b0, 0);
		// sender holds off here until the block has answered everything
		settle();

		for (int p = 0; p < 4; p++) begin
			send_idle  = idle_tab[p];
			recv_stall = stall_tab[p];
			target     = beats_sent + 210;
			while (beats_sent < target)
				random_packet();
			settle();
		end

		$display("sent %0d packet beats over four gap/stall mixes; %0d acks checked",
			beats_sent, ack_count);
		$display("including %0d checksum errors and %0d final-packet acks", err_count, final_count);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
